>>> rtl/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared types and constants for the sorted set insert/delete block.
// ----------------------------------------------------------------------------
package ssid_pkg;

    // Width of one set member
    localparam int VALUE_W = 32;

    // Default table depth
    localparam int DEFAULT_CAPACITY = 32;

    // Operation codes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Command broadcast to every cell in the update cycle
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE
    } cell_cmd_t;

    // Control group from the sequencer to the cell row
    typedef struct packed {
        cell_cmd_t                  cmd;
        logic signed [VALUE_W-1:0]  value;
        logic                       load_shadow;
        logic                       shift_shadow;
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LIST
    } seq_state_t;

endpackage

>>> rtl/sorted_set_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_delete
// Ascending set of distinct signed values kept in a row of cells; every
// operation is followed by a listing of the whole set.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata           tuser               tlast
//  s_axis    in   value[31:0]     op (0 ins, 1 del)   -
//  m_axis    out  element[31:0]   [0] is_empty        is_last
//                                 [1] dropped
//
//  An item is accepted in the idle state, then an update state follows in which
//  every cell shifts or holds at once, then a list state emits the results
//  (at least one). The listing streams out of
//  the shadow chain, one cell per accepted result. A new item is taken only
//  after the last result of the previous listing is accepted. Reset clears
//  the count and sequencer; cell contents need no reset.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete #(
    parameter int CAPACITY = ssid_pkg::DEFAULT_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssid_pkg::VALUE_W-1:0]       s_axis_tdata,   // value
    input  logic                               s_axis_tuser,   // op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssid_pkg::VALUE_W-1:0]       m_axis_tdata,   // element
    output logic [1:0]                         m_axis_tuser,   // is_empty, dropped
    output logic                               m_axis_tlast    // is_last
);
    import ssid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    seq_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       op_reg, op_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic                       dropped_reg, dropped_next;

    cell_ctrl_t                 ctrl;
    logic signed [VALUE_W-1:0]  member_w [CAPACITY];
    logic signed [VALUE_W-1:0]  shadow_w [CAPACITY];
    logic [CAPACITY-1:0]        lt_w;
    logic [CAPACITY-1:0]        eq_w;
    logic [CAPACITY-1:0]        valid_w;

    logic                       found;
    logic                       full;
    logic                       empty;
    logic                       last;

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       left_lt;
        logic signed [VALUE_W-1:0]  left_member;
        logic signed [VALUE_W-1:0]  right_member;
        logic signed [VALUE_W-1:0]  right_shadow;

        assign valid_w[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_lt     = 1'b1;
            assign left_member = '0;
        end
        else
        begin : g_mid
            assign left_lt     = lt_w[i-1];
            assign left_member = member_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_member = member_w[i];
            assign right_shadow = shadow_w[i];
        end
        else
        begin : g_inner
            assign right_member = member_w[i+1];
            assign right_shadow = shadow_w[i+1];
        end

        ssid_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .valid        (valid_w[i]),
            .left_lt      (left_lt),
            .left_member  (left_member),
            .right_member (right_member),
            .right_shadow (right_shadow),
            .member       (member_w[i]),
            .shadow       (shadow_w[i]),
            .lt           (lt_w[i]),
            .eq           (eq_w[i])
        );
    end

    // Row status
    assign found = |eq_w;
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign last  = empty || (idx_reg == count_reg - CNT_W'(1));

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        dropped_next = dropped_reg;

        ctrl.cmd          = CMD_HOLD;
        ctrl.value        = value_reg;
        ctrl.load_shadow  = 1'b0;
        ctrl.shift_shadow = 1'b0;

        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    value_next = s_axis_tdata;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctrl.load_shadow = 1'b1;
                dropped_next     = 1'b0;
                if (op_reg == OP_INSERT)
                begin
                    if (!found && full)
                        dropped_next = 1'b1;
                    else if (!found)
                    begin
                        ctrl.cmd   = CMD_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (found)
                begin
                    ctrl.cmd   = CMD_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
                idx_next   = '0;
                state_next = ST_LIST;
            end
            ST_LIST:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    ctrl.shift_shadow = 1'b1;
                    if (last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + CNT_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Result fields
    assign m_axis_tdata = empty ? '0 : shadow_w[0];
    assign m_axis_tuser = {dropped_reg && !empty, empty};
    assign m_axis_tlast = last;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            dropped_reg <= dropped_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
    end

endmodule

>>> rtl/ssid_cell.sv
// ----------------------------------------------------------------------------
// ssid_cell
// One slot of the sorted row: holds a member and a shadow copy used to
// stream the listing out toward slot 0.
// ----------------------------------------------------------------------------
module ssid_cell (
    input  logic                                   clk,
    input  ssid_pkg::cell_ctrl_t                   ctrl,
    input  logic                                   valid,
    input  logic                                   left_lt,
    input  logic signed [ssid_pkg::VALUE_W-1:0]    left_member,
    input  logic signed [ssid_pkg::VALUE_W-1:0]    right_member,
    input  logic signed [ssid_pkg::VALUE_W-1:0]    right_shadow,
    output logic signed [ssid_pkg::VALUE_W-1:0]    member,
    output logic signed [ssid_pkg::VALUE_W-1:0]    shadow,
    output logic                                   lt,
    output logic                                   eq
);
    import ssid_pkg::*;

    logic signed [VALUE_W-1:0] member_reg;
    logic signed [VALUE_W-1:0] member_next;
    logic signed [VALUE_W-1:0] shadow_reg;
    logic signed [VALUE_W-1:0] shadow_next;

    // Compare own member against the operand
    assign lt = valid && (member_reg < ctrl.value);
    assign eq = valid && (member_reg == ctrl.value);

    // Member update: keep, take operand, or shift from a neighbor
    always_comb
    begin
        member_next = member_reg;
        unique case (ctrl.cmd)
            CMD_INSERT:
            begin
                priority if (lt)
                    member_next = member_reg;
                else if (left_lt)
                    member_next = ctrl.value;
                else
                    member_next = left_member;
            end
            CMD_DELETE:
            begin
                if (!lt)
                    member_next = right_member;
            end
            default:
                member_next = member_reg;
        endcase
    end

    // Shadow: snapshot after update, then shift toward slot 0
    always_comb
    begin
        priority if (ctrl.load_shadow)
            shadow_next = member_next;
        else if (ctrl.shift_shadow)
            shadow_next = right_shadow;
        else
            shadow_next = shadow_reg;
    end

    always_ff @(posedge clk)
    begin
        member_reg <= member_next;
        shadow_reg <= shadow_next;
    end

    assign member = member_reg;
    assign shadow = shadow_reg;

endmodule
